// ===== hw/rtl/tun_pkg.sv =====
`timescale 1ns / 1ps

package tun_pkg;

  // Coordinate width and the widths that follow from it
  localparam int CoordBits = 16;
  localparam int DiffW     = CoordBits + 1;
  localparam int ProdW     = 2 * DiffW;
  localparam int CrossW    = ProdW + 1;
  localparam int MagW      = ProdW;
  localparam int HalfW     = (MagW + 1) / 2;
  localparam int HiW       = MagW - HalfW;
  localparam int SqW       = 2 * MagW;
  localparam int SumW      = SqW + 2;
  localparam int RadPad    = 32;
  localparam int RadW      = SumW + RadPad;
  localparam int RootW     = RadW / 2;
  localparam int SqRemW    = RootW + 3;
  localparam int FracShift = 46;
  localparam int QW        = 31;
  localparam int PreShift  = FracShift - QW;
  localparam int DivRemW   = RootW + 1;
  localparam int NormW     = 32;
  localparam int Lanes     = 3;
  localparam int FrontDepth = 6;

  typedef struct packed {
    logic [CoordBits-1:0] v1_x, v1_y, v1_z;
    logic [CoordBits-1:0] v2_x, v2_y, v2_z;
    logic [CoordBits-1:0] v3_x, v3_y, v3_z;
  } vtx_t;

  // One cross product component as sign and magnitude
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } comp_t;

  typedef struct packed {
    comp_t [Lanes-1:0] c;
    logic              deg;
  } vec_t;

  typedef struct packed {
    logic signed [NormW-1:0] norm_x;
    logic signed [NormW-1:0] norm_y;
    logic signed [NormW-1:0] norm_z;
    logic                    degenerate;
  } res_t;

endpackage

// ===== hw/rtl/tun_if.sv =====
`timescale 1ns / 1ps

interface tun_in_if;
  import tun_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] v1_x, v1_y, v1_z;
  logic signed [CoordBits-1:0] v2_x, v2_y, v2_z;
  logic signed [CoordBits-1:0] v3_x, v3_y, v3_z;

  modport source (output valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
                  input ready);
  modport sink (input valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
                output ready);
endinterface

interface tun_out_if;
  import tun_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [NormW-1:0] norm_x, norm_y, norm_z;
  logic                    degenerate;

  modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
  modport sink (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface

// ===== hw/rtl/tun_front.sv =====
`timescale 1ns / 1ps

module tun_front import tun_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  vtx_t            vtx_i,
  output logic            valid_o,
  output vec_t            vec_o,
  output logic [SumW-1:0] sum_o
);

  logic [FrontDepth-1:0]    vld_q;
  logic signed [DiffW-1:0]  d_d [6];
  logic signed [DiffW-1:0]  d_q [6];
  logic signed [ProdW-1:0]  p_d [6];
  logic signed [ProdW-1:0]  p_q [6];
  logic signed [CrossW-1:0] c_d [Lanes];
  logic signed [CrossW-1:0] cabs [Lanes];
  comp_t                    cm_d [Lanes];
  comp_t                    cm3_q [Lanes];
  comp_t                    cm4_q [Lanes];
  comp_t                    cm5_q [Lanes];
  logic [2*HiW-1:0]         hh_q [Lanes];
  logic [HiW+HalfW-1:0]     hl_q [Lanes];
  logic [2*HalfW-1:0]       ll_q [Lanes];
  logic [SqW-1:0]           sq_d [Lanes];
  logic [SqW-1:0]           sq_q [Lanes];
  logic [SumW-1:0]          sum_d;
  logic [SumW-1:0]          sum_q;
  vec_t                     vec_q;

  // Edge vectors a = v3 - v2 and b = v1 - v2
  always_comb begin
    d_d[0] = DiffW'(signed'(vtx_i.v3_x)) - DiffW'(signed'(vtx_i.v2_x));
    d_d[1] = DiffW'(signed'(vtx_i.v3_y)) - DiffW'(signed'(vtx_i.v2_y));
    d_d[2] = DiffW'(signed'(vtx_i.v3_z)) - DiffW'(signed'(vtx_i.v2_z));
    d_d[3] = DiffW'(signed'(vtx_i.v1_x)) - DiffW'(signed'(vtx_i.v2_x));
    d_d[4] = DiffW'(signed'(vtx_i.v1_y)) - DiffW'(signed'(vtx_i.v2_y));
    d_d[5] = DiffW'(signed'(vtx_i.v1_z)) - DiffW'(signed'(vtx_i.v2_z));
  end

  // Six partial products of the cross product
  always_comb begin
    p_d[0] = d_q[1] * d_q[5];
    p_d[1] = d_q[2] * d_q[4];
    p_d[2] = d_q[2] * d_q[3];
    p_d[3] = d_q[0] * d_q[5];
    p_d[4] = d_q[0] * d_q[4];
    p_d[5] = d_q[1] * d_q[3];
  end

  // Cross product components as sign and magnitude
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      c_d[i]      = CrossW'(p_q[2*i]) - CrossW'(p_q[2*i+1]);
      cabs[i]     = c_d[i][CrossW-1] ? -c_d[i] : c_d[i];
      cm_d[i].neg = c_d[i][CrossW-1];
      cm_d[i].mag = cabs[i][MagW-1:0];
    end
  end

  // Recombine the split squares, then sum them
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      sq_d[i] = (SqW'(hh_q[i]) << (2 * HalfW)) + (SqW'(hl_q[i]) << (HalfW + 1))
              + SqW'(ll_q[i]);
    end
    sum_d = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FrontDepth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
      p_q <= p_d;
      cm3_q <= cm_d;
      for (int i = 0; i < Lanes; i++) begin
        hh_q[i] <= cm3_q[i].mag[MagW-1:HalfW] * cm3_q[i].mag[MagW-1:HalfW];
        hl_q[i] <= cm3_q[i].mag[MagW-1:HalfW] * cm3_q[i].mag[HalfW-1:0];
        ll_q[i] <= cm3_q[i].mag[HalfW-1:0] * cm3_q[i].mag[HalfW-1:0];
        vec_q.c[i] <= cm5_q[i];
      end
      cm4_q <= cm3_q;
      cm5_q <= cm4_q;
      sq_q  <= sq_d;
      sum_q <= sum_d;
      vec_q.deg <= (sum_d == '0);
    end
  end

  assign valid_o = vld_q[FrontDepth-1];
  assign vec_o   = vec_q;
  assign sum_o   = sum_q;

endmodule

// ===== hw/rtl/tun_sqrt.sv =====
`timescale 1ns / 1ps

module tun_sqrt import tun_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  vec_t             vec_i,
  input  logic [SumW-1:0]  sum_i,
  output logic             valid_o,
  output vec_t             vec_o,
  output logic [RootW-1:0] root_o
);

  logic              vld_q  [RootW];
  vec_t              vec_q  [RootW];
  logic [SumW-1:0]   sum_q  [RootW];
  logic [RootW-1:0]  root_q [RootW];
  logic [SqRemW-1:0] rem_q  [RootW];

  // One root bit per stage, restoring digit recurrence on sum * 2^32
  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int Bit = RootW - 1 - k;
    logic              pv;
    vec_t              pvec;
    logic [SumW-1:0]   psum;
    logic [RootW-1:0]  proot;
    logic [SqRemW-1:0] prem;
    logic [RadW-1:0]   rad;
    logic [SqRemW-1:0] rsh;
    logic [SqRemW-1:0] trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign pv    = valid_i;
      assign pvec  = vec_i;
      assign psum  = sum_i;
      assign proot = '0;
      assign prem  = '0;
    end else begin : g_next
      assign pv    = vld_q[k-1];
      assign pvec  = vec_q[k-1];
      assign psum  = sum_q[k-1];
      assign proot = root_q[k-1];
      assign prem  = rem_q[k-1];
    end

    assign rad   = {psum, {RadPad{1'b0}}};
    assign rsh   = {prem[SqRemW-3:0], rad[2*Bit +: 2]};
    assign trial = SqRemW'({proot, 2'b01});
    assign ge    = (rsh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        vec_q[k]  <= pvec;
        sum_q[k]  <= psum;
        root_q[k] <= {proot[RootW-2:0], ge};
        rem_q[k]  <= ge ? (rsh - trial) : rsh;
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign vec_o   = vec_q[RootW-1];
  assign root_o  = root_q[RootW-1];

endmodule

// ===== hw/rtl/tun_div.sv =====
`timescale 1ns / 1ps

module tun_div import tun_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  vec_t             vec_i,
  input  logic [RootW-1:0] root_i,
  output logic             valid_o,
  output vec_t             vec_o,
  output logic [QW-1:0]    q_o [Lanes]
);

  logic               vld_q  [QW];
  vec_t               vec_q  [QW];
  logic [RootW-1:0]   root_q [QW];
  logic [DivRemW-1:0] rem_q  [QW][Lanes];
  logic [QW-1:0]      quo_q  [QW][Lanes];

  // One quotient bit per stage, three lanes share the divisor
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic               pv;
    vec_t               pvec;
    logic [RootW-1:0]   proot;
    logic [DivRemW-1:0] prem [Lanes];
    logic [QW-1:0]      pquo [Lanes];
    logic [DivRemW-1:0] r2   [Lanes];
    logic [DivRemW-1:0] rem_d [Lanes];
    logic [QW-1:0]      quo_d [Lanes];
    logic               ge   [Lanes];

    if (k == 0) begin : g_first
      // numerator mag * 2^46: top bits preload, the rest shift in as zeros
      assign pv    = valid_i;
      assign pvec  = vec_i;
      assign proot = root_i;
      for (genvar i = 0; i < Lanes; i++) begin : g_init
        assign prem[i] = DivRemW'(vec_i.c[i].mag) << PreShift;
        assign pquo[i] = '0;
      end
    end else begin : g_next
      assign pv    = vld_q[k-1];
      assign pvec  = vec_q[k-1];
      assign proot = root_q[k-1];
      assign prem  = rem_q[k-1];
      assign pquo  = quo_q[k-1];
    end

    always_comb begin
      for (int i = 0; i < Lanes; i++) begin
        r2[i]    = {prem[i][DivRemW-2:0], 1'b0};
        ge[i]    = (r2[i] >= DivRemW'(proot));
        rem_d[i] = ge[i] ? (r2[i] - DivRemW'(proot)) : r2[i];
        quo_d[i] = {pquo[i][QW-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        vec_q[k]  <= pvec;
        root_q[k] <= proot;
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign vec_o   = vec_q[QW-1];
  assign q_o     = quo_q[QW-1];

endmodule

// ===== hw/rtl/triangle_unit_normal.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Interface   Payload
// in_i      in   tun_in_if   v1/v2/v3 x,y,z (16 b signed each)
// out_o     out  tun_out_if  norm_x/y/z (32 b Q1.30), degenerate
//
// One triangle per cycle unless stalled; 6 front, 51 root, 31 divide, 1 output stage.
// The depth is set by the bit-per-stage root (51 bits) and quotient (31 bits).
// Reset clears all valid bits and the output buffer's pointers and count; no clearing pass.
// The pipeline stalls as a whole only when the output buffer holds two results.

module triangle_unit_normal import tun_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  tun_in_if.sink   in_i,
  tun_out_if.source out_o
);

  logic             en;
  vtx_t             vtx;
  logic             fr_valid;
  vec_t             fr_vec;
  logic [SumW-1:0]  fr_sum;
  logic             sq_valid;
  vec_t             sq_vec;
  logic [RootW-1:0] sq_root;
  logic             dv_valid;
  vec_t             dv_vec;
  logic [QW-1:0]    dv_q [Lanes];
  logic signed [NormW-1:0] nrm [Lanes];
  res_t             res;
  res_t             buf_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign en       = (cnt_q != 2'd2);
  assign in_i.ready = en;

  assign vtx = '{v1_x: in_i.v1_x, v1_y: in_i.v1_y, v1_z: in_i.v1_z,
                 v2_x: in_i.v2_x, v2_y: in_i.v2_y, v2_z: in_i.v2_z,
                 v3_x: in_i.v3_x, v3_y: in_i.v3_y, v3_z: in_i.v3_z};

  tun_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid), .vtx_i(vtx),
    .valid_o(fr_valid), .vec_o(fr_vec), .sum_o(fr_sum)
  );

  tun_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fr_valid), .vec_i(fr_vec), .sum_i(fr_sum),
    .valid_o(sq_valid), .vec_o(sq_vec), .root_o(sq_root)
  );

  tun_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_valid), .vec_i(sq_vec), .root_i(sq_root),
    .valid_o(dv_valid), .vec_o(dv_vec), .q_o(dv_q)
  );

  // Apply sign, force zeros on a degenerate triangle
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      if (dv_vec.deg) begin
        nrm[i] = '0;
      end else if (dv_vec.c[i].neg) begin
        nrm[i] = -NormW'(dv_q[i]);
      end else begin
        nrm[i] = NormW'(dv_q[i]);
      end
    end
    res.norm_x     = nrm[0];
    res.norm_y     = nrm[1];
    res.norm_z     = nrm[2];
    res.degenerate = dv_vec.deg;
  end

  // Two-entry output buffer
  assign push = dv_valid && en;
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= res;
  end

  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.norm_x     = buf_q[rd_ptr_q].norm_x;
  assign out_o.norm_y     = buf_q[rd_ptr_q].norm_y;
  assign out_o.norm_z     = buf_q[rd_ptr_q].norm_z;
  assign out_o.degenerate = buf_q[rd_ptr_q].degenerate;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer count out of range");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !in_i.ready) else $error("input taken while buffer full");

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.degenerate) |->
      (out_o.norm_x == '0 && out_o.norm_y == '0 && out_o.norm_z == '0))
    else $error("degenerate result with nonzero normal");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !dv_vec.deg) |->
      (dv_q[0] <= QW'(1 << 30) && dv_q[1] <= QW'(1 << 30) && dv_q[2] <= QW'(1 << 30)))
    else $error("normal component above one");

endmodule
